>>> rtl/uks_pkg.sv
// ----------------------------------------------------------------------------
// uks_pkg
// Shared types and constants for the unique key stack: field widths, command
// and status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package uks_pkg;

   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   // request command codes
   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_PEEK = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_UNDER = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_READ   = 2'd2,
      S_FINISH = 2'd3
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture the request beat
      logic scan;      // step the duplicate key scan
      logic read_top;  // read the top entry
      logic finish;    // commit the operation and load the response
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done; // every held key compared
      logic out_free;  // response register can take a new beat
   } sts_type;

endpackage

>>> rtl/uks_ram.sv
// ----------------------------------------------------------------------------
// uks_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module uks_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/uks_dp.sv
// ----------------------------------------------------------------------------
// uks_dp
// Datapath of the unique key stack: request capture, fill level, entry
// memory, duplicate key scan and the response register.
// ----------------------------------------------------------------------------
module uks_dp #(
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_command,
   input  logic signed [uks_pkg::KEY_W-1:0]  req_push_key,
   input  logic signed [uks_pkg::DATA_W-1:0] req_push_data,
   input  uks_pkg::ctl_type                  ctl,
   output uks_pkg::sts_type                  sts,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [uks_pkg::KEY_W-1:0]  rsp_top_key,
   output logic signed [uks_pkg::DATA_W-1:0] rsp_top_data,
   output logic [uks_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic                              rsp_is_empty
);

   localparam int EW = uks_pkg::KEY_W + uks_pkg::DATA_W;

   uks_pkg::cmd_type             cmd_ff, cmd_in;
   logic [uks_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [uks_pkg::DATA_W-1:0]   data_ff, data_in;
   logic [CW-1:0]                fill_ff, fill_in;
   logic [CW-1:0]                scan_ff, scan_in;
   logic                         pend_ff, pend_in;
   logic                         hit_ff, hit_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   uks_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [uks_pkg::KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [uks_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [uks_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                         rsp_empty_ff, rsp_empty_in;

   logic                         issue;
   logic [CW-1:0]                top_idx;
   logic                         is_full;
   logic                         is_zero;
   logic                         push_ok;
   logic                         wr_en;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [EW-1:0]                rd_entry;
   logic [uks_pkg::KEY_W-1:0]    rd_key;
   logic [uks_pkg::DATA_W-1:0]   rd_data;
   logic [CW-1:0]                fill_next;
   logic [CW+uks_pkg::COUNT_W-1:0] count_ext;

   // request capture
   always_comb begin
      cmd_in  = ctl.load ? uks_pkg::cmd_type'(req_command) : cmd_ff;
      key_in  = ctl.load ? req_push_key  : key_ff;
      data_in = ctl.load ? req_push_data : data_ff;
   end

   // duplicate scan: one read issued per cycle, compared in the next cycle
   assign issue   = ctl.scan && (scan_ff < fill_ff);
   assign top_idx = fill_ff - CW'(1);
   assign is_full = (fill_ff == CW'(DEPTH));
   assign is_zero = (fill_ff == '0);

   always_comb begin
      scan_in = ctl.load ? '0 : (issue ? scan_ff + CW'(1) : scan_ff);
      pend_in = issue;
      if (ctl.load) begin
         hit_in = 1'b0;
      end else if (pend_ff && (rd_key == key_ff)) begin
         hit_in = 1'b1;
      end else begin
         hit_in = hit_ff;
      end
   end

   assign sts.scan_done = (scan_ff == fill_ff) && !pend_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // memory read address select
   assign rd_en   = issue || (ctl.read_top && !is_zero);
   assign rd_addr = ctl.scan ? scan_ff[AW-1:0] : top_idx[AW-1:0];
   assign rd_key  = rd_entry[EW-1:uks_pkg::DATA_W];
   assign rd_data = rd_entry[uks_pkg::DATA_W-1:0];

   uks_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data ({key_ff, data_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // operation result and fill update
   assign push_ok = (cmd_ff == uks_pkg::CMD_PUSH) && !hit_ff && !is_full;
   assign wr_en   = ctl.finish && push_ok;

   always_comb begin
      rsp_status_in = uks_pkg::ST_OK;
      rsp_key_in    = '0;
      rsp_data_in   = '0;
      fill_next     = fill_ff;
      case (cmd_ff)
         uks_pkg::CMD_PUSH: begin
            if (hit_ff) begin
               rsp_status_in = uks_pkg::ST_DUP;
            end else if (is_full) begin
               rsp_status_in = uks_pkg::ST_OVER;
            end else begin
               fill_next = fill_ff + CW'(1);
            end
         end
         uks_pkg::CMD_POP: begin
            if (is_zero) begin
               rsp_status_in = uks_pkg::ST_UNDER;
            end else begin
               fill_next   = top_idx;
               rsp_key_in  = rd_key;
               rsp_data_in = rd_data;
            end
         end
         uks_pkg::CMD_PEEK: begin
            if (is_zero) begin
               rsp_status_in = uks_pkg::ST_UNDER;
            end else begin
               rsp_key_in  = rd_key;
               rsp_data_in = rd_data;
            end
         end
         default: begin
         end
      endcase
   end

   assign count_ext    = {{uks_pkg::COUNT_W{1'b0}}, fill_next};
   assign rsp_count_in = count_ext[uks_pkg::COUNT_W-1:0];
   assign rsp_empty_in = (fill_next == '0);
   assign fill_in      = ctl.finish ? fill_next : fill_ff;

   // response beat valid
   always_comb begin
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      data_ff <= data_in;
      if (ctl.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_key     = rsp_key_ff;
   assign rsp_top_data    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   // fill level never passes the stack depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill level above depth");

   // a refused or read-only operation leaves the fill level alone
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      (ctl.finish && ((rsp_status_in != uks_pkg::ST_OK) ||
                      (cmd_ff == uks_pkg::CMD_PEEK))) |=> $stable(fill_ff))
      else $error("fill level changed on refused or peek operation");

   // memory is written only by a unique push with room left
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((cmd_ff == uks_pkg::CMD_PUSH) && !hit_ff && (fill_ff < CW'(DEPTH))))
      else $error("entry written without a valid push");

   // a pending compare always follows an issued scan read
   a_pend_follows: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(issue))
      else $error("compare pending without a scan read");

endmodule

>>> rtl/uks_ctrl.sv
// ----------------------------------------------------------------------------
// uks_ctrl
// Controller of the unique key stack: sequences request capture, the
// duplicate key scan, the top entry read and the response commit.
// ----------------------------------------------------------------------------
module uks_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_command,
   output logic             req_stall,
   output uks_pkg::ctl_type ctl,
   input  uks_pkg::sts_type sts
);

   uks_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uks_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_command == uks_pkg::CMD_PUSH) begin
                  state_in = uks_pkg::S_SCAN;
               end else begin
                  state_in = uks_pkg::S_READ;
               end
            end
         end
         uks_pkg::S_SCAN: begin
            if (sts.scan_done) begin
               state_in = uks_pkg::S_FINISH;
            end
         end
         uks_pkg::S_READ: begin
            state_in = uks_pkg::S_FINISH;
         end
         uks_pkg::S_FINISH: begin
            if (sts.out_free) begin
               state_in = uks_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = uks_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall    = 1'b1;
      ctl.load     = 1'b0;
      ctl.scan     = 1'b0;
      ctl.read_top = 1'b0;
      ctl.finish   = 1'b0;
      case (state_ff)
         uks_pkg::S_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         uks_pkg::S_SCAN: begin
            ctl.scan = 1'b1;
         end
         uks_pkg::S_READ: begin
            ctl.read_top = 1'b1;
         end
         uks_pkg::S_FINISH: begin
            ctl.finish = sts.out_free;
         end
         default: begin
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uks_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a captured push always goes through the key scan
   a_push_scans: assert property (@(posedge clock) disable iff (reset)
      (ctl.load && (req_command == uks_pkg::CMD_PUSH)) |=> (state_ff == uks_pkg::S_SCAN))
      else $error("push did not start the key scan");

   // commit happens only once the response register is free
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (sts.out_free && (state_ff == uks_pkg::S_FINISH)))
      else $error("commit while response register busy");

   // a commit returns the controller to idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> (state_ff == uks_pkg::S_IDLE))
      else $error("controller not idle after commit");

endmodule

>>> rtl/unique_key_stack.sv
// ----------------------------------------------------------------------------
// unique_key_stack
// Last-in first-out stack of key and data pairs with a duplicate key check
// on push, plus underflow and overflow reporting.
// ----------------------------------------------------------------------------
// sequence: a push scans the held keys (one entry memory read per held
//   key) before its result is loaded; pop, peek and no-op read the top
//   entry instead
// throughput: one item at a time; the next beat is accepted once the
//   previous result is loaded
// reset: fill level and handshake state clear at once; the entry memory is
//   not cleared and needs no clearing pass
module unique_key_stack #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic signed [uks_pkg::KEY_W-1:0]  req_push_key,
   input  logic signed [uks_pkg::DATA_W-1:0] req_push_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic signed [uks_pkg::KEY_W-1:0]  rsp_top_key,
   output logic signed [uks_pkg::DATA_W-1:0] rsp_top_data,
   output logic [uks_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic                              rsp_is_empty
);

   uks_pkg::ctl_type ctl;
   uks_pkg::sts_type sts;

   // sequencing
   uks_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .ctl         (ctl),
      .sts         (sts)
   );

   // storage, scan and response
   uks_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_push_key    (req_push_key),
      .req_push_data   (req_push_data),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_data    (rsp_top_data),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

>>> sim/unique_key_stack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_stack_test
// Self-checking bench for the unique key stack. A behavioral copy of the stack
// predicts every response beat, covering duplicate refusal, overflow,
// underflow and peek. Directed corner cases run first, then a long
// backpressure hold, then random fill, drain and mixed phases. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module unique_key_stack_test;

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 1200000;
   localparam int ITEM_TARGET = 1900;
   localparam int POOL_SIZE   = 96;
   localparam int TAIL_CYCLES = 80;

   typedef struct packed {
      uks_pkg::status_type           status;
      logic [uks_pkg::KEY_W-1:0]     top_key;
      logic [uks_pkg::DATA_W-1:0]    top_data;
      logic [uks_pkg::COUNT_W-1:0]   entry_count;
      logic                          is_empty;
   } stack_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [1:0]                        req_command = uks_pkg::CMD_NOP;
   logic signed [uks_pkg::KEY_W-1:0]  req_push_key = '0;
   logic signed [uks_pkg::DATA_W-1:0] req_push_data = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [1:0]                        rsp_status;
   logic signed [uks_pkg::KEY_W-1:0]  rsp_top_key;
   logic signed [uks_pkg::DATA_W-1:0] rsp_top_data;
   logic [uks_pkg::COUNT_W-1:0]       rsp_entry_count;
   logic                              rsp_is_empty;

   // predicted stack contents, slot 0 is the bottom
   logic [uks_pkg::KEY_W-1:0]  shadow_keys [DEPTH];
   logic [uks_pkg::DATA_W-1:0] shadow_data [DEPTH];
   int                         shadow_fill = 0;

   stack_result_type           pending_results [$];
   logic [uks_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];
   int                         error_count = 0;
   int                         beats_sent = 0;
   int                         cycle_count = 0;
   int                         hold_left = 0;
   int                         stall_left = 0;
   bit                         send_idle_en = 1'b1;
   bit                         rsp_idle_en = 1'b1;

   unique_key_stack #(.DEPTH(DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_push_key    (req_push_key),
      .req_push_data   (req_push_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_data    (rsp_top_data),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("unique_key_stack regression: fail");
         $finish;
      end
   end

   // apply one operation to the shadow stack and return the response it gives
   function automatic stack_result_type apply_stack_op(uks_pkg::cmd_type cmd,
                                                       logic [uks_pkg::KEY_W-1:0] k,
                                                       logic [uks_pkg::DATA_W-1:0] d);
      stack_result_type r;
      logic             hit;
      r = '0;
      r.status = uks_pkg::ST_OK;
      hit = 1'b0;
      case (cmd)
         uks_pkg::CMD_PUSH: begin
            for (int i = 0; i < shadow_fill; i++)
               if (shadow_keys[i] == k) hit = 1'b1;
            // duplicate check wins over the full check
            if (hit) begin
               r.status = uks_pkg::ST_DUP;
            end else if (shadow_fill >= DEPTH) begin
               r.status = uks_pkg::ST_OVER;
            end else begin
               shadow_keys[shadow_fill] = k;
               shadow_data[shadow_fill] = d;
               shadow_fill++;
            end
         end
         uks_pkg::CMD_POP: begin
            if (shadow_fill == 0) begin
               r.status = uks_pkg::ST_UNDER;
            end else begin
               shadow_fill--;
               r.top_key  = shadow_keys[shadow_fill];
               r.top_data = shadow_data[shadow_fill];
            end
         end
         uks_pkg::CMD_PEEK: begin
            if (shadow_fill == 0) begin
               r.status = uks_pkg::ST_UNDER;
            end else begin
               r.top_key  = shadow_keys[shadow_fill-1];
               r.top_data = shadow_data[shadow_fill-1];
            end
         end
         default: ;
      endcase
      r.entry_count = shadow_fill[uks_pkg::COUNT_W-1:0];
      r.is_empty    = (shadow_fill == 0);
      return r;
   endfunction

   // gap length: mostly short, a few long
   function automatic int pick_gap(bit allow_zero);
      int r;
      r = $urandom_range(0, 99);
      if (allow_zero && r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(15, 50);
   endfunction

   // drive one request beat, hold it until accepted, then idle for a random gap, possibly none
   task automatic send_beat(uks_pkg::cmd_type cmd, logic [uks_pkg::KEY_W-1:0] k,
                            logic [uks_pkg::DATA_W-1:0] d);
      int gap;
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_push_key  <= k;
      req_push_data <= d;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_stack_op(cmd, k, d));
      beats_sent++;
      gap = send_idle_en ? pick_gap(1'b1) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: check each accepted beat, then choose the next stall
   initial begin
      stack_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response beat with nothing expected");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_top_key !== want.top_key) begin
                  $error("top_key: expected %h, actual %h", want.top_key, rsp_top_key);
                  error_count++;
               end
               if (rsp_top_data !== want.top_data) begin
                  $error("top_data: expected %h, actual %h", want.top_data, rsp_top_data);
                  error_count++;
               end
               if (rsp_entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d", want.entry_count,
                         rsp_entry_count);
                  error_count++;
               end
               if (rsp_is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d", want.is_empty,
                         rsp_is_empty);
                  error_count++;
               end
            end
         end
         // long hold-off first, then random stall runs
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap(1'b0) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // pop, peek and no-op on an empty stack
   task automatic test_empty_stack();
      send_beat(uks_pkg::CMD_POP, 32'h1234_5678, 32'h9abc_def0);
      send_beat(uks_pkg::CMD_PEEK, '1, '1);
      send_beat(uks_pkg::CMD_NOP, 32'h8000_0000, 32'h7fff_ffff);
   endtask

   // extreme keys and data, duplicate refusal, peek, no-op and pops to empty
   task automatic test_extreme_entries();
      send_beat(uks_pkg::CMD_PUSH, 32'h8000_0000, 32'h7fff_ffff);
      send_beat(uks_pkg::CMD_PUSH, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(uks_pkg::CMD_PUSH, 32'h0000_0000, 32'h0000_0000);
      send_beat(uks_pkg::CMD_PUSH, 32'hffff_ffff, 32'hffff_ffff);
      send_beat(uks_pkg::CMD_PUSH, 32'h8000_0000, 32'h0000_0001);
      send_beat(uks_pkg::CMD_PUSH, 32'h0000_0000, 32'h5555_aaaa);
      send_beat(uks_pkg::CMD_PEEK, 32'h0, 32'h0);
      send_beat(uks_pkg::CMD_NOP, 32'hdead_beef, 32'hcafe_f00d);
      send_beat(uks_pkg::CMD_POP, 32'h0, 32'h0);
      send_beat(uks_pkg::CMD_POP, 32'h0, 32'h0);
      send_beat(uks_pkg::CMD_PEEK, 32'h0, 32'h0);
      send_beat(uks_pkg::CMD_POP, 32'h0, 32'h0);
      send_beat(uks_pkg::CMD_POP, 32'h0, 32'h0);
      send_beat(uks_pkg::CMD_POP, 32'h0, 32'h0);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_idle_en = 1'b0;
      hold_left = 400;
      for (int i = 0; i < 12; i++)
         send_beat((i % 3 == 2) ? uks_pkg::CMD_POP : uks_pkg::CMD_PUSH, $urandom, $urandom);
      send_idle_en = 1'b1;
   endtask

   function automatic uks_pkg::cmd_type pick_command(int push_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return uks_pkg::CMD_NOP;
      if (r < push_pct) return uks_pkg::CMD_PUSH;
      return ($urandom_range(0, 3) == 0) ? uks_pkg::CMD_PEEK : uks_pkg::CMD_POP;
   endfunction

   // keys: some held (duplicates), some from a shared pool, the rest fresh
   function automatic logic [uks_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2 && shadow_fill > 0) return shadow_keys[$urandom_range(0, shadow_fill-1)];
      if (r < 5) return key_pool[$urandom_range(0, POOL_SIZE-1)];
      return $urandom;
   endfunction

   function automatic logic [uks_pkg::DATA_W-1:0] pick_data();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_op(int push_pct);
      send_beat(pick_command(push_pct), pick_key(), pick_data());
   endtask

   // random fill-to-full, drain-to-empty and mixed phases
   task automatic test_random_traffic();
      int kind;
      int guard;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      while (beats_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 2);
         send_idle_en = ($urandom_range(0, 3) != 0);
         rsp_idle_en  = ($urandom_range(0, 3) != 0);
         guard = 0;
         case (kind)
            0: begin
               // fill until full, then beat on the full stack
               while (shadow_fill < DEPTH && guard < 400) begin
                  random_op(85);
                  guard++;
               end
               repeat ($urandom_range(3, 10)) random_op(85);
            end
            1: begin
               // drain until empty, then a few underflows
               while (shadow_fill > 0 && guard < 400) begin
                  random_op(15);
                  guard++;
               end
               repeat ($urandom_range(2, 8)) random_op(15);
            end
            default: begin
               repeat ($urandom_range(20, 80)) random_op(50);
            end
         endcase
      end
      send_idle_en = 1'b1;
      rsp_idle_en  = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_stack();
      test_extreme_entries();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("unique_key_stack regression: pass");
      end else begin
         $display("unique_key_stack regression: fail");
      end
      $finish;
   end

endmodule
